>>> rtl/core/rc6_pkg.sv
// Shared types, constants and word functions for the RC6 block cipher.
`default_nettype none

package rc6_pkg;

    // Default round count
    localparam int RC6_ROUNDS = 20;

    localparam int WORD_W  = 32;
    localparam int CMD_W   = 2;
    localparam int INDEX_W = 6;
    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 128;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 2'd0,
        CMD_ENC  = 2'd1,
        CMD_DEC  = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_ROUND,
        S_POST
    } state_t;

    function automatic word_t rotl(input word_t x, input logic [4:0] s);
        logic [2*WORD_W-1:0] dbl;
        dbl = {x, x} << s;
        return dbl[2*WORD_W-1:WORD_W];
    endfunction

    function automatic word_t rotr(input word_t x, input logic [4:0] s);
        logic [2*WORD_W-1:0] dbl;
        dbl = {x, x} >> s;
        return dbl[WORD_W-1:0];
    endfunction

    // f(x) = x*(2x+1) mod 2^32, rotated left by 5
    function automatic word_t mix(input word_t x);
        word_t p;
        p = x * {x[WORD_W-2:0], 1'b1};
        return {p[WORD_W-6:0], p[WORD_W-1:WORD_W-5]};
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/rc6_block_cipher.sv
// RC6-32 block cipher top level: key table banks, round sequencer and output register.
`default_nettype none

// RC6-32 with ROUNDS rounds (default 20). Every request carries a command in
// tuser: load one round-key word, encrypt a block, or decrypt a block; code 3
// is taken and dropped. Round keys sit in two synchronous memories, even
// words in one bank and odd words in the other, so the pair a round needs is
// read together into a register in the cycle before its use. The key table
// has no reset: every entry a block request uses must be loaded first. Loads
// give no response and leave the sequencer idle; a load with an index of
// 2*ROUNDS+4 or more is dropped. A block request runs accept, input
// whitening, one round per cycle through the two mix multipliers, then output
// whitening into the output register. When the result is registered the
// sequencer is back in idle and takes a new request. The output register holds
// a finished block while the sink stalls; only the next block's final step
// waits on it.
module rc6_block_cipher
#(
    parameter int ROUNDS = rc6_pkg::RC6_ROUNDS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output      logic                             s_axis_tready,
    // key_index[5:0], key_word[37:6], block_word0[69:38], block_word1[101:70],
    // block_word2[133:102], block_word3[165:134], zero pad[167:166]
    input  wire logic [rc6_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // command[1:0]
    input  wire logic [rc6_pkg::CMD_W-1:0]        s_axis_tuser,
    output      logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // out_word0[31:0], out_word1[63:32], out_word2[95:64], out_word3[127:96]
    output      logic [rc6_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    import rc6_pkg::*;

    localparam int KEY_WORDS = 2 * ROUNDS + 4;
    localparam int BANK_DEPTH = ROUNDS + 2;
    localparam int AW = $clog2(BANK_DEPTH);
    localparam int RW = $clog2(ROUNDS + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(ROUNDS + 1);
    localparam logic [RW-1:0] LAST_RND = RW'(ROUNDS);

    // Input field positions
    localparam int KW_LSB = INDEX_W;
    localparam int B0_LSB = KW_LSB + WORD_W;
    localparam int B1_LSB = B0_LSB + WORD_W;
    localparam int B2_LSB = B1_LSB + WORD_W;
    localparam int B3_LSB = B2_LSB + WORD_W;

    // Key banks: entry n of a bank holds key word 2n (even) or 2n+1 (odd)
    word_t key_even_mem [BANK_DEPTH];
    word_t key_odd_mem  [BANK_DEPTH];
    word_t key_even_reg, key_odd_reg;

    state_t state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next, rd_addr;
    logic [RW-1:0] rnd_reg, rnd_next;
    logic dec_reg, dec_next;
    word_t a_reg, b_reg, c_reg, d_reg;
    word_t a_next, b_next, c_next, d_next;
    logic out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    cmd_t cmd;
    logic [INDEX_W-1:0] key_index;
    word_t key_word;
    logic in_accept, is_block, load_ok, post_go;
    logic [AW-1:0] wr_addr;
    word_t t_mix, u_mix;
    word_t enc_a, enc_c, dec_a, dec_c;

    assign cmd       = cmd_t'(s_axis_tuser);
    assign key_index = s_axis_tdata[INDEX_W-1:0];
    assign key_word  = s_axis_tdata[KW_LSB +: WORD_W];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign is_block  = (cmd == CMD_ENC) || (cmd == CMD_DEC);
    assign load_ok   = in_accept && (cmd == CMD_LOAD)
                       && ({1'b0, key_index} < 7'(KEY_WORDS));
    assign wr_addr   = AW'(key_index[INDEX_W-1:1]);
    assign post_go   = (state_reg == S_POST) && (!out_valid_reg || m_axis_tready);

    // Key table: one write port (loads), one read per bank each cycle
    always_ff @(posedge clk)
    begin
        if (load_ok && !key_index[0])
        begin
            key_even_mem[wr_addr] <= key_word;
        end
        if (load_ok && key_index[0])
        begin
            key_odd_mem[wr_addr] <= key_word;
        end
        key_even_reg <= key_even_mem[rd_addr];
        key_odd_reg  <= key_odd_mem[rd_addr];
    end

    // Round datapath: two shared mix multipliers; decrypt applies f to the words
    // that land in B and D after the word rotation (old A and old C)
    assign t_mix = mix(dec_reg ? a_reg : b_reg);
    assign u_mix = mix(dec_reg ? c_reg : d_reg);
    assign enc_a = rotl(a_reg ^ t_mix, u_mix[4:0]) + key_even_reg;
    assign enc_c = rotl(c_reg ^ u_mix, t_mix[4:0]) + key_odd_reg;
    assign dec_a = rotr(d_reg - key_even_reg, u_mix[4:0]) ^ t_mix;
    assign dec_c = rotr(b_reg - key_odd_reg, t_mix[4:0]) ^ u_mix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        rnd_reg      <= rnd_next;
        dec_reg      <= dec_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        d_reg        <= d_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        rnd_next       = rnd_reg;
        dec_next       = dec_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        s_axis_tready  = 1'b0;
        rd_addr        = addr_reg;

        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                dec_next = (cmd == CMD_DEC);
                // first key pair: word 0/1 for encrypt, last pair for decrypt
                rd_addr = (cmd == CMD_DEC) ? LAST_ADDR : '0;
                if (in_accept && is_block)
                begin
                    a_next = s_axis_tdata[B0_LSB +: WORD_W];
                    b_next = s_axis_tdata[B1_LSB +: WORD_W];
                    c_next = s_axis_tdata[B2_LSB +: WORD_W];
                    d_next = s_axis_tdata[B3_LSB +: WORD_W];
                    addr_next = (cmd == CMD_DEC) ? LAST_ADDR - AW'(1) : AW'(1);
                    state_next = S_PRE;
                end
            end
            S_PRE:
            begin
                if (dec_reg)
                begin
                    a_next = a_reg - key_even_reg;
                    c_next = c_reg - key_odd_reg;
                    addr_next = addr_reg - AW'(1);
                end
                else
                begin
                    b_next = b_reg + key_even_reg;
                    d_next = d_reg + key_odd_reg;
                    addr_next = addr_reg + AW'(1);
                end
                rnd_next = RW'(1);
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                if (dec_reg)
                begin
                    a_next = dec_a;
                    b_next = a_reg;
                    c_next = dec_c;
                    d_next = c_reg;
                    addr_next = addr_reg - AW'(1);
                end
                else
                begin
                    a_next = b_reg;
                    b_next = enc_c;
                    c_next = d_reg;
                    d_next = enc_a;
                    addr_next = addr_reg + AW'(1);
                end
                rnd_next = rnd_reg + RW'(1);
                if (rnd_reg == LAST_RND)
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                // re-read the final pair so a stall keeps it in the read register
                rd_addr = dec_reg ? '0 : LAST_ADDR;
                if (post_go)
                begin
                    if (dec_reg)
                    begin
                        out_data_next = {d_reg - key_odd_reg, c_reg,
                                         b_reg - key_even_reg, a_reg};
                    end
                    else
                    begin
                        out_data_next = {d_reg, c_reg + key_odd_reg,
                                         b_reg, a_reg + key_even_reg};
                    end
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Round counter stays within the round range while rounds run
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> (rnd_reg >= RW'(1) && rnd_reg <= LAST_RND))
        else $error("round counter out of range");

    // A finished block always lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        post_go |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("final step did not post a result");

    // An accepted block request starts the whitening step next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && is_block) |=> (state_reg == S_PRE))
        else $error("block request not started");

    // The final step never overwrites a result the sink has not taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !post_go)
        else $error("pending result overwritten");

endmodule

`default_nettype wire
